// File: rtl/mtq_pkg.sv
`timescale 1ns / 1ps

package mtq_pkg;

    localparam logic [2:0] FUNC_REGISTER   = 3'd0;
    localparam logic [2:0] FUNC_DELETE     = 3'd1;
    localparam logic [2:0] FUNC_ACTIVATE   = 3'd2;
    localparam logic [2:0] FUNC_DEACTIVATE = 3'd3;
    localparam logic [2:0] FUNC_TICK       = 3'd4;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_ALREADY_REG = 2'd1;
    localparam logic [1:0] ST_NOT_REG     = 2'd2;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_STOP = 2'd1;
    localparam logic [1:0] ACT_ARM  = 2'd2;

    localparam logic KIND_FIRED = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  id;
        logic        in_range;
        logic [63:0] expire;
        logic [63:0] now;
    } cmd_t;

endpackage

// File: rtl/mtq_ram.sv
`timescale 1ns / 1ps

module mtq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mtq_front.sv
`timescale 1ns / 1ps

module mtq_front
    import mtq_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  func,
    input  logic [3:0]  timer_id,
    input  logic [63:0] expire_ns,
    input  logic [63:0] now_ns,
    output logic        busy,
    output logic        q_valid,
    output cmd_t        q_cmd,
    input  logic        q_pop
);

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;
    cmd_t       in_cmd;

    assign busy    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = ent_reg[rd_ptr_reg];
    assign push    = start && !busy;
    assign pop     = q_pop && q_valid;

    always_comb
    begin
        in_cmd.func     = func;
        in_cmd.id       = timer_id;
        in_cmd.in_range = (32'(timer_id) < NUM_SLOTS);
        in_cmd.expire   = expire_ns;
        in_cmd.now      = now_ns;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/mtq_back.sv
`timescale 1ns / 1ps

module mtq_back
    import mtq_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        valid,
    output logic        kind,
    output logic [3:0]  fired_id,
    output logic [1:0]  status,
    output logic [1:0]  host_action,
    output logic [63:0] host_delay_ns,
    output logic        last
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]           state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic [NUM_SLOTS-1:0] pend_reg, pend_next;
    logic [CW-1:0]        iss_reg, iss_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [SW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                 best_vld_reg, best_vld_next;
    logic                 best_s_reg, best_s_next;
    logic [63:0]          best_d_reg, best_d_next;
    logic                 ex_vld_reg, ex_vld_next;
    logic [63:0]          ex_d_reg, ex_d_next;

    logic                 valid_reg, valid_next;
    logic                 kind_reg, kind_next;
    logic [3:0]           id_reg, id_next;
    logic [1:0]           status_reg, status_next;
    logic [1:0]           act_reg, act_next;
    logic [63:0]          delay_reg, delay_next;
    logic                 last_reg, last_next;

    logic                 ram_we;
    logic [SW-1:0]        ram_raddr;
    logic [63:0]          ram_rdata;
    logic [SW-1:0]        s;
    logic                 is_tick;
    logic                 excl;
    logic                 fire;
    logic                 cand;
    logic                 ex_cand;
    logic [1:0]           sel_act;
    logic [63:0]          sel_d;

    assign s       = SW'(cmd_reg.id);
    assign is_tick = (cmd_reg.func == FUNC_TICK);
    assign excl    = (cmd_reg.func == FUNC_DELETE) || (cmd_reg.func == FUNC_DEACTIVATE);

    mtq_ram #(
        .WIDTH (64),
        .DEPTH (NUM_SLOTS)
    ) u_deadline (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s),
        .wdata (cmd_reg.expire),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        used_next     = used_reg;
        pend_next     = pend_reg;
        iss_next      = iss_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        best_vld_next = best_vld_reg;
        best_s_next   = best_s_reg;
        best_d_next   = best_d_reg;
        ex_vld_next   = ex_vld_reg;
        ex_d_next     = ex_d_reg;
        valid_next    = 1'b0;
        kind_next     = kind_reg;
        id_next       = id_reg;
        status_next   = status_reg;
        act_next      = act_reg;
        delay_next    = delay_reg;
        last_next     = last_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_raddr     = iss_reg[SW-1:0];
        fire          = 1'b0;
        cand          = 1'b0;
        ex_cand       = 1'b0;
        sel_act       = ACT_NONE;
        sel_d         = best_d_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                iss_next      = '0;
                best_vld_next = 1'b0;
                best_s_next   = 1'b0;
                ex_vld_next   = 1'b0;
                kind_next     = KIND_DONE;
                id_next       = cmd_reg.id;
                status_next   = ST_OK;
                act_next      = ACT_NONE;
                delay_next    = '0;
                last_next     = 1'b1;
                unique case (cmd_reg.func) inside
                    FUNC_REGISTER:
                    begin
                        valid_next = 1'b1;
                        state_next = S_IDLE;
                        if (!cmd_reg.in_range)
                        begin
                            status_next = ST_NOT_REG;
                        end
                        else if (used_reg[s])
                        begin
                            status_next = ST_ALREADY_REG;
                        end
                        else
                        begin
                            used_next[s] = 1'b1;
                            pend_next[s] = 1'b0;
                        end
                    end
                    FUNC_DELETE, FUNC_ACTIVATE, FUNC_DEACTIVATE:
                    begin
                        if (!(cmd_reg.in_range && used_reg[s]))
                        begin
                            status_next = ST_NOT_REG;
                            valid_next  = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            if (cmd_reg.func == FUNC_ACTIVATE)
                            begin
                                ram_we       = 1'b1;
                                pend_next[s] = 1'b1;
                            end
                            state_next = S_SCAN;
                        end
                    end
                    FUNC_TICK:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        valid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (iss_reg < CW'(NUM_SLOTS))
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = iss_reg[SW-1:0];
                    iss_next     = iss_reg + CW'(1);
                end
                if (cmp_vld_reg)
                begin
                    fire    = is_tick && pend_reg[cmp_idx_reg] && (ram_rdata <= cmd_reg.now);
                    cand    = pend_reg[cmp_idx_reg] && !fire;
                    ex_cand = cand && !(excl && (cmp_idx_reg == s));
                    if (cand && (!best_vld_reg || (ram_rdata < best_d_reg)))
                    begin
                        best_vld_next = 1'b1;
                        best_d_next   = ram_rdata;
                        best_s_next   = (cmp_idx_reg == s);
                    end
                    if (ex_cand && (!ex_vld_reg || (ram_rdata < ex_d_reg)))
                    begin
                        ex_vld_next = 1'b1;
                        ex_d_next   = ram_rdata;
                    end
                    if (fire)
                    begin
                        pend_next[cmp_idx_reg] = 1'b0;
                        valid_next  = 1'b1;
                        kind_next   = KIND_FIRED;
                        id_next     = 4'(cmp_idx_reg);
                        status_next = ST_OK;
                        act_next    = ACT_NONE;
                        delay_next  = '0;
                        last_next   = 1'b0;
                    end
                end
                else if (iss_reg == CW'(NUM_SLOTS))
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (excl)
                begin
                    if (best_vld_reg && best_s_reg)
                    begin
                        sel_act = ex_vld_reg ? ACT_ARM : ACT_STOP;
                        sel_d   = ex_d_reg;
                    end
                    pend_next[s] = 1'b0;
                    if (cmd_reg.func == FUNC_DELETE)
                    begin
                        used_next[s] = 1'b0;
                    end
                end
                else if (best_vld_reg)
                begin
                    sel_act = ACT_ARM;
                end
                valid_next  = 1'b1;
                kind_next   = KIND_DONE;
                id_next     = cmd_reg.id;
                status_next = ST_OK;
                act_next    = sel_act;
                last_next   = 1'b1;
                if ((sel_act == ACT_ARM) && (sel_d > cmd_reg.now))
                begin
                    delay_next = sel_d - cmd_reg.now;
                end
                else
                begin
                    delay_next = '0;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        cmp_idx_reg <= cmp_idx_next;
        best_s_reg  <= best_s_next;
        best_d_reg  <= best_d_next;
        ex_d_reg    <= ex_d_next;
        kind_reg    <= kind_next;
        id_reg      <= id_next;
        status_reg  <= status_next;
        act_reg     <= act_next;
        delay_reg   <= delay_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            pend_reg     <= '0;
            iss_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            best_vld_reg <= 1'b0;
            ex_vld_reg   <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            pend_reg     <= pend_next;
            iss_reg      <= iss_next;
            cmp_vld_reg  <= cmp_vld_next;
            best_vld_reg <= best_vld_next;
            ex_vld_reg   <= ex_vld_next;
            valid_reg    <= valid_next;
        end
    end

    assign valid         = valid_reg;
    assign kind          = kind_reg;
    assign fired_id      = id_reg;
    assign status        = status_reg;
    assign host_action   = act_reg;
    assign host_delay_ns = delay_reg;
    assign last          = last_reg;

endmodule

// File: rtl/multiplexed_timer_queue.sv
`timescale 1ns / 1ps

// channel   handshake             payload
// ------    ---------             -------
// command   start / busy          func, timer_id, expire_ns, now_ns
// result    valid (one cycle)     kind, fired_id, status, host_action,
//                                 host_delay_ns, last
//
// a two-entry command queue takes items while the engine works; busy is high when it is full.
// register, failed and unknown operations finish in the execute state; others scan every slot,
// bound by the single read port of the deadline memory, one slot per cycle.
// fired items leave during the scan, the completion (last) from the finish state after it.
// reset clears slot flags and the queue; the deadline memory is not reset, only pending
// slots use their deadlines.
// results are presented for one cycle and cannot be held off.

module multiplexed_timer_queue
    import mtq_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [3:0]  timer_id,
    input  logic [63:0] expire_ns,
    input  logic [63:0] now_ns,
    output logic        valid,
    output logic        kind,
    output logic [3:0]  fired_id,
    output logic [1:0]  status,
    output logic [1:0]  host_action,
    output logic [63:0] host_delay_ns,
    output logic        last
);

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    mtq_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (func),
        .timer_id  (timer_id),
        .expire_ns (expire_ns),
        .now_ns    (now_ns),
        .busy      (busy),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop)
    );

    mtq_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .valid         (valid),
        .kind          (kind),
        .fired_id      (fired_id),
        .status        (status),
        .host_action   (host_action),
        .host_delay_ns (host_delay_ns),
        .last          (last)
    );

endmodule
